// File: hw/rtl/kls_pkg.sv
// Shared types, codes and widths for the keyframe linear sampler.
`timescale 1ns / 1ps

package kls_pkg;

   localparam int VAL_W   = 32;           // Q16.16 time and value width
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 3;
   localparam int KT_W    = 7;            // key_total field width
   localparam int ALPHA_W = 16;           // unsigned Q0.16 blend factor
   localparam int DIV_W   = VAL_W + 1;    // time difference, one guard bit
   localparam int PROD_W  = DIV_W + ALPHA_W + 1;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_SAMPLE = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_SAMPLE   = 3'd0,
      ST_FALLBACK = 3'd1,
      ST_APPENDED = 3'd2,
      ST_FULL     = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      REG_FALLBACK_X = 2'd0,
      REG_FALLBACK_Y = 2'd1,
      REG_FALLBACK_Z = 2'd2
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_FIRST,
      S_LAST,
      S_SCAN,
      S_DIV,
      S_MUL,
      S_ADD,
      S_OUT
   } state_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] key_time;
      logic signed [VAL_W-1:0] x;
      logic signed [VAL_W-1:0] y;
      logic signed [VAL_W-1:0] z;
   } key_type;

   localparam int KEY_W = $bits(key_type);

   // controller to datapath strobes
   typedef struct packed {
      logic capture;
      logic do_clear;
      logic do_append;
      logic do_fallback;
      logic rd_first;
      logic take_first;
      logic rd_last;
      logic load_clamp;
      logic scan_start;
      logic rd_next;
      logic div_init;
      logic div_step;
      logic mul_step;
      logic add_step;
      logic out_load;
   } ctrl_cmd_type;

   // datapath to controller flags
   typedef struct packed {
      logic kind_clear;
      logic kind_append;
      logic empty;
      logic t_le;       // query time <= time of key on the read port
      logic t_ge;       // query time >= time of key on the read port
      logic div_last;
      logic comp_last;
      logic out_free;
   } dp_stat_type;

endpackage

// File: hw/rtl/kls_req_if.sv
// Request channel: command and keyframe or query payload.
`timescale 1ns / 1ps

interface kls_req_if import kls_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic signed [VAL_W-1:0] time_point;
   logic signed [VAL_W-1:0] in_x;
   logic signed [VAL_W-1:0] in_y;
   logic signed [VAL_W-1:0] in_z;

   modport source (output valid, cmd, time_point, in_x, in_y, in_z, input ready);
   modport sink   (input valid, cmd, time_point, in_x, in_y, in_z, output ready);
endinterface

// File: hw/rtl/kls_rsp_if.sv
// Response channel: status, sampled vector and key count.
`timescale 1ns / 1ps

interface kls_rsp_if import kls_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [STAT_W-1:0]       status;
   logic signed [VAL_W-1:0] out_x;
   logic signed [VAL_W-1:0] out_y;
   logic signed [VAL_W-1:0] out_z;
   logic [KT_W-1:0]         key_total;

   modport source (output valid, status, out_x, out_y, out_z, key_total, input ready);
   modport sink   (input valid, status, out_x, out_y, out_z, key_total, output ready);
endinterface

// File: hw/rtl/kls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kls_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/kls_ctrl.sv
// Sequencer for the keyframe sampler: dispatch, key scan, divide, blend.
`timescale 1ns / 1ps

module kls_ctrl import kls_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (stat.kind_clear || stat.kind_append || stat.empty) state_in = S_OUT;
            else state_in = S_FIRST;
         end
         S_FIRST: begin
            if (stat.t_le) state_in = S_OUT;
            else state_in = S_LAST;
         end
         S_LAST: begin
            if (stat.t_ge) state_in = S_OUT;
            else state_in = S_SCAN;
         end
         S_SCAN: begin
            if (!stat.t_ge) state_in = S_DIV;
         end
         S_DIV: begin
            if (stat.div_last) state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            if (stat.comp_last) state_in = S_OUT;
            else state_in = S_MUL;
         end
         S_OUT: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_DISPATCH: begin
            if (stat.kind_clear) cmd.do_clear = 1'b1;
            else if (stat.kind_append) cmd.do_append = 1'b1;
            else if (stat.empty) cmd.do_fallback = 1'b1;
            else cmd.rd_first = 1'b1;
         end
         S_FIRST: begin
            cmd.take_first = 1'b1;
            if (stat.t_le) cmd.load_clamp = 1'b1;
            else cmd.rd_last = 1'b1;
         end
         S_LAST: begin
            if (stat.t_ge) cmd.load_clamp = 1'b1;
            else cmd.scan_start = 1'b1;
         end
         S_SCAN: begin
            if (!stat.t_ge) cmd.div_init = 1'b1;
            else cmd.rd_next = 1'b1;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
         end
         S_ADD: begin
            cmd.add_step = 1'b1;
         end
         S_OUT: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: hw/rtl/kls_dpath.sv
// Datapath: key table, scan registers, restoring divider, shared blend multiplier.
`timescale 1ns / 1ps

module kls_dpath import kls_pkg::*; #(
   parameter int MAX_KEYS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   output dp_stat_type             stat,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic signed [VAL_W-1:0] req_time_point,
   input  logic signed [VAL_W-1:0] req_in_x,
   input  logic signed [VAL_W-1:0] req_in_y,
   input  logic signed [VAL_W-1:0] req_in_z,
   input  logic signed [VAL_W-1:0] fallback_x,
   input  logic signed [VAL_W-1:0] fallback_y,
   input  logic signed [VAL_W-1:0] fallback_z,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output status_type              rsp_status,
   output logic signed [VAL_W-1:0] rsp_out_x,
   output logic signed [VAL_W-1:0] rsp_out_y,
   output logic signed [VAL_W-1:0] rsp_out_z,
   output logic [KT_W-1:0]         rsp_key_total
);

   localparam int AW     = $clog2(MAX_KEYS);
   localparam int CW     = $clog2(MAX_KEYS + 1);
   localparam int DCNT_W = $clog2(ALPHA_W);

   // control state
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     scan_ff, scan_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [1:0]        comp_ff, comp_in;
   logic              out_valid_ff, out_valid_in;

   // payload
   cmd_type                 item_cmd_ff, item_cmd_in;
   logic signed [VAL_W-1:0] item_t_ff, item_t_in;
   logic signed [VAL_W-1:0] item_x_ff, item_x_in;
   logic signed [VAL_W-1:0] item_y_ff, item_y_in;
   logic signed [VAL_W-1:0] item_z_ff, item_z_in;
   key_type                 prev_ff, prev_in;
   key_type                 cur_ff, cur_in;
   logic [DIV_W-1:0]        rem_ff, rem_in;
   logic [DIV_W-1:0]        dt_ff, dt_in;
   logic [ALPHA_W-1:0]      quo_ff, quo_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   status_type              res_status_ff, res_status_in;
   logic signed [VAL_W-1:0] res_x_ff, res_x_in;
   logic signed [VAL_W-1:0] res_y_ff, res_y_in;
   logic signed [VAL_W-1:0] res_z_ff, res_z_in;
   status_type              out_status_ff, out_status_in;
   logic signed [VAL_W-1:0] out_x_ff, out_x_in;
   logic signed [VAL_W-1:0] out_y_ff, out_y_in;
   logic signed [VAL_W-1:0] out_z_ff, out_z_in;
   logic [KT_W-1:0]         out_kt_ff, out_kt_in;

   // combinational
   logic [KEY_W-1:0]        rd_data;
   key_type                 rd_key;
   key_type                 wr_key;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           last_idx;
   logic                    full;
   logic                    wr_en;
   logic [DIV_W:0]          div_shift;
   logic [DIV_W:0]          div_sub;
   logic                    dt_ok;
   logic [ALPHA_W-1:0]      alpha;
   logic signed [ALPHA_W:0] alpha_s;
   logic signed [DIV_W-1:0] diff;
   logic signed [VAL_W-1:0] base;
   logic signed [VAL_W-1:0] blend;

   assign rd_key   = key_type'(rd_data);
   assign full     = (count_ff == CW'(MAX_KEYS));
   assign last_idx = AW'(count_ff - CW'(1));
   assign wr_en    = cmd.do_append && !full;
   assign wr_key   = '{key_time: item_t_ff, x: item_x_ff, y: item_y_ff, z: item_z_ff};

   kls_ram #(
      .WIDTH(KEY_W),
      .DEPTH(MAX_KEYS)
   ) u_keys (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(wr_key),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // alpha is forced to zero for a span that is not positive
   assign dt_ok     = !dt_ff[DIV_W-1] && (dt_ff != '0);
   assign alpha     = dt_ok ? quo_ff : '0;
   assign alpha_s   = $signed({1'b0, alpha});
   assign div_shift = {rem_ff, 1'b0};
   assign div_sub   = div_shift - {1'b0, dt_ff};

   always_comb begin
      case (comp_ff)
         2'd0: begin
            diff = {cur_ff.x[VAL_W-1], cur_ff.x} - {prev_ff.x[VAL_W-1], prev_ff.x};
            base = prev_ff.x;
         end
         2'd1: begin
            diff = {cur_ff.y[VAL_W-1], cur_ff.y} - {prev_ff.y[VAL_W-1], prev_ff.y};
            base = prev_ff.y;
         end
         default: begin
            diff = {cur_ff.z[VAL_W-1], cur_ff.z} - {prev_ff.z[VAL_W-1], prev_ff.z};
            base = prev_ff.z;
         end
      endcase
   end

   // floor(p / 2^16) is an arithmetic shift; only the low word survives
   assign blend = base + VAL_W'(prod_ff[ALPHA_W +: VAL_W]);

   always_comb begin
      stat = '0;
      case (item_cmd_ff)
         CMD_CLEAR:  stat.kind_clear  = 1'b1;
         CMD_APPEND: stat.kind_append = 1'b1;
         default:    stat.kind_clear  = 1'b0;
      endcase
      stat.empty     = (count_ff == '0);
      stat.t_le      = ($signed(item_t_ff) <= $signed(rd_key.key_time));
      stat.t_ge      = ($signed(item_t_ff) >= $signed(rd_key.key_time));
      stat.div_last  = (div_cnt_ff == DCNT_W'(ALPHA_W - 1));
      stat.comp_last = (comp_ff == 2'd2);
      stat.out_free  = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      count_in      = count_ff;
      scan_in       = scan_ff;
      div_cnt_in    = div_cnt_ff;
      comp_in       = comp_ff;
      out_valid_in  = out_valid_ff;
      item_cmd_in   = item_cmd_ff;
      item_t_in     = item_t_ff;
      item_x_in     = item_x_ff;
      item_y_in     = item_y_ff;
      item_z_in     = item_z_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      rem_in        = rem_ff;
      dt_in         = dt_ff;
      quo_in        = quo_ff;
      prod_in       = prod_ff;
      res_status_in = res_status_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_z_in      = res_z_ff;
      out_status_in = out_status_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_z_in      = out_z_ff;
      out_kt_in     = out_kt_ff;
      rd_addr       = '0;

      if (cmd.capture) begin
         item_cmd_in = cmd_type'(req_cmd);
         item_t_in   = req_time_point;
         item_x_in   = req_in_x;
         item_y_in   = req_in_y;
         item_z_in   = req_in_z;
      end

      if (cmd.do_clear) begin
         count_in      = '0;
         res_status_in = ST_CLEARED;
         res_x_in      = '0;
         res_y_in      = '0;
         res_z_in      = '0;
      end

      if (cmd.do_append) begin
         res_x_in = '0;
         res_y_in = '0;
         res_z_in = '0;
         if (full) begin
            res_status_in = ST_FULL;
         end else begin
            count_in      = count_ff + CW'(1);
            res_status_in = ST_APPENDED;
         end
      end

      if (cmd.do_fallback) begin
         res_status_in = ST_FALLBACK;
         res_x_in      = fallback_x;
         res_y_in      = fallback_y;
         res_z_in      = fallback_z;
      end

      if (cmd.rd_first) rd_addr = '0;
      if (cmd.take_first) prev_in = rd_key;
      if (cmd.rd_last) rd_addr = last_idx;

      if (cmd.load_clamp) begin
         res_status_in = ST_SAMPLE;
         res_x_in      = rd_key.x;
         res_y_in      = rd_key.y;
         res_z_in      = rd_key.z;
      end

      if (cmd.scan_start) begin
         rd_addr = AW'(1);
         scan_in = AW'(1);
      end

      // key j on the read port is not past the query: slide the window up
      if (cmd.rd_next) begin
         prev_in = rd_key;
         rd_addr = scan_ff + AW'(1);
         scan_in = scan_ff + AW'(1);
      end

      if (cmd.div_init) begin
         cur_in        = rd_key;
         rem_in        = {item_t_ff[VAL_W-1], item_t_ff}
                       - {prev_ff.key_time[VAL_W-1], prev_ff.key_time};
         dt_in         = {rd_key.key_time[VAL_W-1], rd_key.key_time}
                       - {prev_ff.key_time[VAL_W-1], prev_ff.key_time};
         quo_in        = '0;
         div_cnt_in    = '0;
         comp_in       = 2'd0;
         res_status_in = ST_SAMPLE;
      end

      // restoring division, one quotient bit per cycle
      if (cmd.div_step) begin
         if (!div_sub[DIV_W]) begin
            rem_in = div_sub[DIV_W-1:0];
            quo_in = {quo_ff[ALPHA_W-2:0], 1'b1};
         end else begin
            rem_in = div_shift[DIV_W-1:0];
            quo_in = {quo_ff[ALPHA_W-2:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff + DCNT_W'(1);
      end

      if (cmd.mul_step) prod_in = diff * alpha_s;

      if (cmd.add_step) begin
         case (comp_ff)
            2'd0:    res_x_in = blend;
            2'd1:    res_y_in = blend;
            default: res_z_in = blend;
         endcase
         comp_in = comp_ff + 2'd1;
      end

      if (cmd.out_load) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_x_in      = res_x_ff;
         out_y_in      = res_y_ff;
         out_z_in      = res_z_ff;
         out_kt_in     = KT_W'(count_ff);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_ff      <= '0;
         div_cnt_ff   <= '0;
         comp_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         div_cnt_ff   <= div_cnt_in;
         comp_ff      <= comp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_cmd_ff   <= item_cmd_in;
      item_t_ff     <= item_t_in;
      item_x_ff     <= item_x_in;
      item_y_ff     <= item_y_in;
      item_z_ff     <= item_z_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      rem_ff        <= rem_in;
      dt_ff         <= dt_in;
      quo_ff        <= quo_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_z_ff      <= res_z_in;
      out_status_ff <= out_status_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_z_ff      <= out_z_in;
      out_kt_ff     <= out_kt_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_out_z     = out_z_ff;
   assign rsp_key_total = out_kt_ff;

endmodule

// File: hw/rtl/keyframe_linear_sampler_top.sv
// Top level of the keyframe linear sampler: CSR block, sequencer and datapath.
//
//  channel   | dir | transfer when              | payload
//  ----------+-----+----------------------------+-----------------------------------------
//  req_chan  | in  | valid && ready             | cmd, time_point, in_x, in_y, in_z
//  rsp_chan  | out | valid && ready             | status, out_x, out_y, out_z, key_total
//  csr_*     | in  | psel && penable && pwrite  | fallback_x/y/z at 0x0 / 0x4 / 0x8
//
// Flow: one item at a time. Clear, append and fallback items go straight from dispatch
// to the output state. A sample ends early when clamped to the first or to the last key,
// else it runs the linear scan for the upper key (one key table read per cycle),
// restoring division for alpha and 3 multiply/add pairs on the single shared multiplier.
// Reset (synchronous, active high) empties the track and zeroes the fallback
// registers; the key table itself is not cleared, entries past the count are never read.
// The result sits in an output register; the next request transfer can be taken
// while it waits, but a new result is held back until the previous one is taken.
`timescale 1ns / 1ps

module keyframe_linear_sampler_top import kls_pkg::*; #(
   parameter int MAX_KEYS = 64
) (
   input  logic              clock,
   input  logic              reset,
   kls_req_if.sink           req_chan,
   kls_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // ---------------------------------------------------------------- CSR block
   logic signed [VAL_W-1:0] fallback_x_ff, fallback_x_in;
   logic signed [VAL_W-1:0] fallback_y_ff, fallback_y_in;
   logic signed [VAL_W-1:0] fallback_z_ff, fallback_z_in;
   logic                    csr_wr;
   csr_idx_type             csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_idx_type'(csr_paddr[3:2]);

   always_comb begin
      fallback_x_in = fallback_x_ff;
      fallback_y_in = fallback_y_ff;
      fallback_z_in = fallback_z_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_FALLBACK_X: fallback_x_in = csr_pwdata;
            REG_FALLBACK_Y: fallback_y_in = csr_pwdata;
            REG_FALLBACK_Z: fallback_z_in = csr_pwdata;
            default:        fallback_x_in = fallback_x_ff;  // write beyond the map is dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_FALLBACK_X: csr_prdata = fallback_x_ff;
         REG_FALLBACK_Y: csr_prdata = fallback_y_ff;
         REG_FALLBACK_Z: csr_prdata = fallback_z_ff;
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fallback_x_ff <= '0;
         fallback_y_ff <= '0;
         fallback_z_ff <= '0;
      end else begin
         fallback_x_ff <= fallback_x_in;
         fallback_y_ff <= fallback_y_in;
         fallback_z_ff <= fallback_z_in;
      end
   end

   // ------------------------------------------------------ sequencer / datapath
   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;
   status_type   rsp_status;

   kls_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .stat     (dp_stat),
      .cmd      (ctrl_cmd)
   );

   kls_dpath #(
      .MAX_KEYS(MAX_KEYS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (ctrl_cmd),
      .stat          (dp_stat),
      .req_cmd       (req_chan.cmd),
      .req_time_point(req_chan.time_point),
      .req_in_x      (req_chan.in_x),
      .req_in_y      (req_chan.in_y),
      .req_in_z      (req_chan.in_z),
      .fallback_x    (fallback_x_ff),
      .fallback_y    (fallback_y_ff),
      .fallback_z    (fallback_z_ff),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_status    (rsp_status),
      .rsp_out_x     (rsp_chan.out_x),
      .rsp_out_y     (rsp_chan.out_y),
      .rsp_out_z     (rsp_chan.out_z),
      .rsp_key_total (rsp_chan.key_total)
   );

   assign rsp_chan.status = rsp_status;

   // --------------------------------------------------------------- assertions

   // one item in flight: the request side is closed in the cycle after a request transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while an item is in flight");

   // clear and append results carry a zero vector
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == ST_APPENDED || rsp_chan.status == ST_FULL
                         || rsp_chan.status == ST_CLEARED)
      |-> rsp_chan.out_x == '0 && rsp_chan.out_y == '0 && rsp_chan.out_z == '0)
      else $error("non-sample result with a nonzero vector");

   // a dropped append reports a full track
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_FULL |-> rsp_chan.key_total == KT_W'(MAX_KEYS))
      else $error("full status with key count below capacity");

   // a clear leaves no keys behind
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_CLEARED |-> rsp_chan.key_total == '0)
      else $error("clear result with keys still counted");

endmodule

// File: bench/tb_kls_sample_checker.sv
// Response checker for the keyframe linear sampler: track model, prediction and compare.
`timescale 1ns / 1ps

module kls_sample_checker import kls_pkg::*; #(
   parameter int MAX_KEYS = 64
) (
   input  logic              clock,
   input  logic              reset,
   kls_req_if                req_mon,
   kls_rsp_if                rsp_mon,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic              csr_pready,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output int                fail_count,
   output int                pending
);

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic signed [VAL_W-1:0] x;
      logic signed [VAL_W-1:0] y;
      logic signed [VAL_W-1:0] z;
      logic [KT_W-1:0]         total;
   } track_reply_type;

   // model copy of the track
   logic signed [VAL_W-1:0] key_t [MAX_KEYS];
   logic signed [VAL_W-1:0] key_x [MAX_KEYS];
   logic signed [VAL_W-1:0] key_y [MAX_KEYS];
   logic signed [VAL_W-1:0] key_z [MAX_KEYS];
   int unsigned             key_n = 0;
   logic signed [VAL_W-1:0] fb_x = '0;
   logic signed [VAL_W-1:0] fb_y = '0;
   logic signed [VAL_W-1:0] fb_z = '0;

   track_reply_type replies_due [$];
   int              errors = 0;

   task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                  input logic [VAL_W-1:0] want);
      $display("[%0t] %s mismatch: got %h want %h", $time, what, got, want);
      errors++;
   endtask

   task automatic check_field(input string what, input logic [VAL_W-1:0] got,
                              input logic [VAL_W-1:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // v0 + floor(alpha * (v1 - v0) / 2^16); arithmetic shift floors negatives
   function automatic logic signed [VAL_W-1:0] blend(input logic signed [VAL_W-1:0] v0,
                                                     input logic signed [VAL_W-1:0] v1,
                                                     input longint alpha);
      longint prod;
      prod = (longint'(v1) - longint'(v0)) * alpha;
      return VAL_W'(longint'(v0) + (prod >>> 16));
   endfunction

   function automatic track_reply_type run_command(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [VAL_W-1:0] t,
                                                   input logic signed [VAL_W-1:0] vx,
                                                   input logic signed [VAL_W-1:0] vy,
                                                   input logic signed [VAL_W-1:0] vz);
      track_reply_type r;
      int unsigned     last, lo, hi, i;
      longint          t0, dt, alpha;
      r = '0;
      if (cmd == CMD_CLEAR) begin
         key_n = 0;
         r.status = ST_CLEARED;
      end else if (cmd == CMD_APPEND) begin
         if (key_n < MAX_KEYS) begin
            key_t[key_n] = t;
            key_x[key_n] = vx;
            key_y[key_n] = vy;
            key_z[key_n] = vz;
            key_n++;
            r.status = ST_APPENDED;
         end else begin
            r.status = ST_FULL;
         end
      end else if (key_n == 0) begin
         // code 3 lands here too: any code other than clear or append is a sample
         r.status = ST_FALLBACK;
         r.x = fb_x;
         r.y = fb_y;
         r.z = fb_z;
      end else begin
         r.status = ST_SAMPLE;
         last = key_n - 1;
         lo = last;
         hi = last;
         if (t <= key_t[0]) begin
            lo = 0;
            hi = 0;
         end else if (t < key_t[last]) begin
            for (i = 0; i < last; i++) begin
               if (t < key_t[i + 1]) begin
                  lo = i;
                  hi = i + 1;
                  break;
               end
            end
         end
         if (lo == hi) begin
            r.x = key_x[lo];
            r.y = key_y[lo];
            r.z = key_z[lo];
         end else begin
            t0 = key_t[lo];
            dt = longint'(key_t[hi]) - t0;
            alpha = 0;
            if (dt > 0 && longint'(t) >= t0) begin
               alpha = ((longint'(t) - t0) <<< 16) / dt;
               if (alpha > 65535)
                  alpha = 65535;
            end
            r.x = blend(key_x[lo], key_x[hi], alpha);
            r.y = blend(key_y[lo], key_y[hi], alpha);
            r.z = blend(key_z[lo], key_z[hi], alpha);
         end
      end
      r.total = KT_W'(key_n);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      track_reply_type want;
      if (reset) begin
         key_n = 0;
         fb_x = '0;
         fb_y = '0;
         fb_z = '0;
         replies_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (replies_due.size() == 0) begin
               report_mismatch("response with nothing pending, status", VAL_W'(rsp_mon.status),
                               '0);
            end else begin
               want = replies_due.pop_front();
               check_field("status", VAL_W'(rsp_mon.status), VAL_W'(want.status));
               check_field("out_x", rsp_mon.out_x, want.x);
               check_field("out_y", rsp_mon.out_y, want.y);
               check_field("out_z", rsp_mon.out_z, want.z);
               check_field("key_total", VAL_W'(rsp_mon.key_total), VAL_W'(want.total));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_idx_type'(csr_paddr[CSR_AW-1:2]))
               REG_FALLBACK_X: fb_x = csr_pwdata;
               REG_FALLBACK_Y: fb_y = csr_pwdata;
               REG_FALLBACK_Z: fb_z = csr_pwdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            replies_due.push_back(run_command(req_mon.cmd, req_mon.time_point, req_mon.in_x,
                                              req_mon.in_y, req_mon.in_z));
      end
      fail_count <= errors;
      pending    <= replies_due.size();
   end

endmodule

// File: bench/tb_keyframe_linear_sampler_top.sv
// Testbench top for the keyframe linear sampler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_keyframe_linear_sampler_top;
   import kls_pkg::*;

   localparam int MAX_KEYS     = 64;
   localparam int RANDOM_ITEMS = 900;
   localparam int PHASES       = 4;
   localparam int DIRECTED     = 23;
   // one long receiver hold-off, started once this many items have gone in
   localparam int HOLD_AT      = 350;
   localparam int HOLD_CYCLES  = 300;
   // slowest correct gap between transfers: a full-table sample plus the longest
   // receiver stall and the longest request gap, or the hold-off above;
   // the limit is a few times the worst of these
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 120;

   localparam logic [CMD_W-1:0]        CMD_UNUSED = 2'd3;   // decoded as a sample
   localparam logic signed [VAL_W-1:0] Q_MIN      = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] Q_MAX      = 32'sh7fff_ffff;
   localparam logic signed [VAL_W-1:0] Q_ONE      = 32'sh0001_0000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int fail_count;
   int pending;
   int req_sent    = 0;
   int idle_cycles = 0;
   int req_burst   = 0;
   int rsp_burst   = 0;
   bit hold_done   = 1'b0;

   // times of the keys the block should hold, used only to aim sample times
   logic signed [VAL_W-1:0] track_times [$];

   kls_req_if req_bus ();
   kls_rsp_if rsp_bus ();

   always #6 clock = ~clock;

   keyframe_linear_sampler_top #(
      .MAX_KEYS (MAX_KEYS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   kls_sample_checker #(
      .MAX_KEYS (MAX_KEYS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // Watchdog: any cycle with a transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- helpers

   function automatic logic signed [VAL_W-1:0] rand_q16();
      return $urandom();
   endfunction

   function automatic logic signed [VAL_W-1:0] clamp_q16(input longint v);
      if (v > Q_MAX)
         return Q_MAX;
      if (v < Q_MIN)
         return Q_MIN;
      return VAL_W'(v);
   endfunction

   // key value: mostly full-range random, with the rails mixed in
   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return Q_MIN;
         1:       return Q_MAX;
         2:       return '0;
         3:       return -32'sd1;
         default: return rand_q16();
      endcase
   endfunction

   // spacing to the next key time; zero spans and out-of-order keys included
   function automatic longint time_step();
      case ($urandom_range(0, 15))
         0, 1:       return 0;
         2:          return -longint'($urandom_range(1, 32'h0010_0000));
         3, 4, 5, 6: return longint'($urandom_range(1, 32'h0000_ffff));
         7:          return longint'($urandom_range(1, 32'h3fff_ffff));
         default:    return longint'($urandom_range(1, 32'h00ff_ffff));
      endcase
   endfunction

   // query time aimed at the held keys: on a key, between keys, or past either end
   function automatic logic signed [VAL_W-1:0] query_time();
      int unsigned n;
      longint      base;
      n = track_times.size();
      if (n == 0 || $urandom_range(0, 7) == 0)
         return rand_q16();
      base = track_times[$urandom_range(0, n - 1)];
      case ($urandom_range(0, 5))
         0:       return VAL_W'(base);
         1:       return clamp_q16(longint'(track_times[0])
                                   - longint'($urandom_range(0, 32'h000f_ffff)));
         2:       return clamp_q16(longint'(track_times[n - 1])
                                   + longint'($urandom_range(0, 32'h000f_ffff)));
         3:       return clamp_q16(base + longint'($urandom_range(0, 32'h0001_ffff)));
         default: return clamp_q16(base + longint'($urandom_range(0, 32'h01ff_ffff))
                                   - longint'(32'h0100_0000));
      endcase
   endfunction

   // APB write: setup phase, access phase, then psel drops and the bus idles
   task automatic csr_write(input csr_idx_type idx, input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_fallbacks(input logic signed [VAL_W-1:0] fx,
                                input logic signed [VAL_W-1:0] fy,
                                input logic signed [VAL_W-1:0] fz);
      csr_write(REG_FALLBACK_X, fx);
      csr_write(REG_FALLBACK_Y, fy);
      csr_write(REG_FALLBACK_Z, fz);
   endtask

   // One request transfer. Returns right after the accepting edge with valid still
   // high, so a back-to-back item keeps valid up without dropping it.
   task automatic send_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [VAL_W-1:0] t,
                               input logic signed [VAL_W-1:0] vx,
                               input logic signed [VAL_W-1:0] vy,
                               input logic signed [VAL_W-1:0] vz);
      int gap;
      if (req_burst > 0) begin
         gap = 0;
         req_burst--;
      end else if ($urandom_range(0, 29) == 0) begin
         gap = 0;
         req_burst = $urandom_range(10, 40);
      end else begin
         gap = $urandom_range(0, 18);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.time_point <= t;
      req_bus.in_x       <= vx;
      req_bus.in_y       <= vy;
      req_bus.in_z       <= vz;
      do @(posedge clock); while (!req_bus.ready);
      req_sent++;
      if (cmd == CMD_CLEAR)
         track_times.delete();
      else if (cmd == CMD_APPEND && track_times.size() < MAX_KEYS)
         track_times.push_back(t);
   endtask

   // drop valid and wait until every expected response has come back
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   // Short hand-picked run: fallback, clamping at both ends, interpolation
   // across the full time range, code 3, zero span, out-of-order keys.
   task automatic run_directed();
      send_command(CMD_SAMPLE, '0, '0, '0, '0);                 // empty track
      send_command(CMD_UNUSED, Q_MAX, Q_MIN, Q_MAX, '0);        // code 3, empty
      send_command(CMD_CLEAR, '0, '0, '0, '0);
      send_command(CMD_APPEND, Q_MIN, Q_MIN, Q_MAX, '0);
      send_command(CMD_SAMPLE, Q_MAX, '0, '0, '0);              // single key
      send_command(CMD_APPEND, Q_MAX, Q_MAX, Q_MIN, -32'sd1);
      send_command(CMD_SAMPLE, Q_MIN, '0, '0, '0);              // on first key
      send_command(CMD_SAMPLE, '0, '0, '0, '0);                 // midway, widest span
      send_command(CMD_SAMPLE, Q_MAX, '0, '0, '0);              // on last key
      send_command(CMD_SAMPLE, Q_MAX - 1, '0, '0, '0);          // alpha near one
      send_command(CMD_UNUSED, Q_MIN + 1, '0, '0, '0);          // code 3, tiny alpha
      send_command(CMD_APPEND, Q_MAX, 32'sd1, 32'sd2, 32'sd3);  // repeated time
      send_command(CMD_SAMPLE, Q_MAX, '0, '0, '0);
      send_command(CMD_APPEND, '0, Q_ONE, -Q_ONE, Q_MAX);       // out of order
      send_command(CMD_SAMPLE, 32'sd100, '0, '0, '0);
      send_command(CMD_SAMPLE, -32'sd5, '0, '0, '0);
      send_command(CMD_CLEAR, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      send_command(CMD_SAMPLE, Q_MIN, '0, '0, '0);              // fallback after clear
      send_command(CMD_APPEND, Q_ONE, '0, '0, '0);
      send_command(CMD_APPEND, 32'sh0003_0000, Q_ONE, -Q_ONE, Q_MAX);
      send_command(CMD_SAMPLE, 32'sh0002_0000, '0, '0, '0);     // half way
      send_command(CMD_SAMPLE, 32'sh0001_0001, '0, '0, '0);     // rounding toward -inf
      send_command(CMD_SAMPLE, 32'sh0002_ffff, '0, '0, '0);
   endtask

   // One track: usually a clear, keys with mostly rising times (now and then a
   // run long enough to overflow the table), then samples aimed at the keys.
   task automatic run_track_episode();
      int          n_keys;
      int          n_samples;
      int          k;
      int          pick;
      longint      t;
      logic [CMD_W-1:0] cmd;
      if ($urandom_range(0, 9) != 0)
         send_command(CMD_CLEAR, rand_q16(), rand_q16(), rand_q16(), rand_q16());
      pick = $urandom_range(0, 19);
      if (pick == 0)
         n_keys = 0;
      else if (pick == 1)
         n_keys = $urandom_range(58, 70);
      else
         n_keys = $urandom_range(1, 10);
      if (track_times.size() > 0)
         t = track_times[$];
      else
         t = longint'(rand_q16()) >>> $urandom_range(0, 14);
      for (k = 0; k < n_keys; k++) begin
         t = clamp_q16(t + time_step());
         send_command(CMD_APPEND, VAL_W'(t), pick_value(), pick_value(), pick_value());
      end
      n_samples = $urandom_range(1, 8);
      for (k = 0; k < n_samples; k++) begin
         cmd = ($urandom_range(0, 11) == 0) ? CMD_UNUSED : CMD_SAMPLE;
         send_command(cmd, query_time(), rand_q16(), rand_q16(), rand_q16());
      end
      // stray item with a random code and payload
      if ($urandom_range(0, 4) == 0)
         send_command(CMD_W'($urandom_range(0, 3)), rand_q16(), rand_q16(), rand_q16(),
                      rand_q16());
   endtask

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      int phase;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_CLEAR;
      req_bus.time_point = '0;
      req_bus.in_x       = '0;
      req_bus.in_y       = '0;
      req_bus.in_z       = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_fallbacks(Q_MIN, Q_MAX, 32'sh0001_8000);
      run_directed();

      // random phases, each under a different fallback setting
      for (phase = 1; phase <= PHASES; phase++) begin
         wait_idle();
         case (phase)
            1:       set_fallbacks(rand_q16(), rand_q16(), rand_q16());
            2:       set_fallbacks(Q_MAX, Q_MIN, -32'sd1);
            3:       set_fallbacks('0, '0, '0);
            default: set_fallbacks(rand_q16(), rand_q16(), rand_q16());
         endcase
         while (req_sent < DIRECTED + phase * RANDOM_ITEMS / PHASES)
            run_track_episode();
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Response side: random stall before each transfer, bursts with no stall,
   // and one long hold-off so the block backs up into its request port.
   initial begin : receiver
      int stall;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!hold_done && req_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (rsp_burst > 0) begin
            stall = 0;
            rsp_burst--;
         end else if ($urandom_range(0, 29) == 0) begin
            stall = 0;
            rsp_burst = $urandom_range(10, 40);
         end else begin
            stall = $urandom_range(0, 18);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

endmodule

// File: sim.f
hw/rtl/kls_pkg.sv
hw/rtl/kls_req_if.sv
hw/rtl/kls_rsp_if.sv
hw/rtl/kls_ram.sv
hw/rtl/kls_ctrl.sv
hw/rtl/kls_dpath.sv
hw/rtl/keyframe_linear_sampler_top.sv
bench/tb_kls_sample_checker.sv
bench/tb_keyframe_linear_sampler_top.sv
